@@ sv/thkr_pkg.sv @@
`default_nettype none
package thkr_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int MAP_ENTRIES_DEF = 4;
    localparam int MAX_RESULTS     = 10;

    localparam logic [1:0] MODE_OFF      = 2'd0;
    localparam logic [1:0] MODE_ON       = 2'd1;
    localparam logic [1:0] MODE_NO_DELAY = 2'd2;

    localparam logic [2:0] REG_DEFAULT_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_INITIAL_MODE    = 3'd1;
    localparam logic [2:0] REG_ENABLE_CODE     = 3'd2;
    localparam logic [2:0] REG_DISABLE_CODE    = 3'd3;
    localparam logic [2:0] REG_BINDING_BASE    = 3'd4;

    localparam logic [15:0] RESET_TIMEOUT = 16'd200;
    localparam logic [1:0]  RESET_MODE    = MODE_ON;

    // One held key event.
    typedef struct packed {
        logic [7:0]  addr;
        logic [15:0] code;
        logic        pressed;
        logic [15:0] stamp;
    } held_t;

    // Which value the datapath presents on the result port.
    typedef enum logic [1:0] {
        SRC_INPUT,    // the accepted event, unchanged
        SRC_HEAD,     // the queue head, unchanged
        SRC_TAP,      // the queue head with the binding's output code
        SRC_COURTESY  // release of the queue head's own code
    } out_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;     // latch the input item
        logic     push;        // append the latched event to the queue
        logic     push_press;  // push it as a press
        logic     pop;         // drop the queue head
        logic     set_mode_on;
        logic     set_mode_off;
        logic     set_binding; // load pending binding from search result
        logic     load_out;    // load the output register
        out_src_t out_src;
        logic     out_last;
    } thkr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       is_tick;
        logic       pass_through;
        logic       is_enable;
        logic       is_disable;
        logic       mode_off;
        logic       mode_nd;
        logic       on;
        logic       off;
        logic       empty;
        logic       full;
        logic       one_left;
        logic       head_match;
        logic       timed_out;
        logic       bind_found;
        logic       tap_ok;
    } thkr_sts_t;

endpackage
`default_nettype wire

@@ sv/thkr_ram.sv @@
`default_nettype none
module thkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata_reg
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ sv/thkr_datapath.sv @@
`default_nettype none
module thkr_datapath
    import thkr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    input  wire  [2:0]  cfg_index,
    input  wire  [48:0] cfg_data,
    input  wire         s_kind,
    input  wire  [7:0]  s_key_addr,
    input  wire         s_addr_valid,
    input  wire  [15:0] s_key_code,
    input  wire         s_toggled_on,
    input  wire         s_toggled_off,
    input  wire         s_injected,
    input  wire  [15:0] s_now_ms,
    input  thkr_cmd_t   cmd,
    output thkr_sts_t   sts,
    output logic [7:0]  m_out_addr,
    output logic [15:0] m_out_code,
    output logic        m_out_pressed,
    output logic        m_last
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int BW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int HW = $bits(held_t);

    logic [15:0] timeout_reg;
    logic [1:0]  mode_reg;
    logic [15:0] enable_reg;
    logic [15:0] disable_reg;
    logic [48:0] bind_reg [MAP_ENTRIES];

    logic        kind_reg, avalid_reg, on_reg, off_reg, inj_reg;
    logic [7:0]  addr_reg;
    logic [15:0] code_reg, now_reg;

    logic [QW-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [BW-1:0] pend_reg;
    logic          pend_valid_reg;

    logic [BW-1:0] bind_idx;
    logic          bind_hit;
    held_t         head;
    logic [HW-1:0] head_bits;
    held_t         wr_item;
    logic [15:0]   to_eff, elapsed;
    logic [BW-1:0] rd_next;

    // Priority search over a handful of bindings: lowest index wins.
    always_comb begin
        bind_hit = 1'b0;
        bind_idx = '0;
        for (int i = MAP_ENTRIES - 1; i >= 0; i--) begin
            if (bind_reg[i][48] && bind_reg[i][47:32] == code_reg) begin
                bind_hit = 1'b1;
                bind_idx = BW'(i);
            end
        end
    end

    assign rd_next = '0;

    always_comb begin
        wr_item.addr    = addr_reg;
        wr_item.code    = code_reg;
        wr_item.pressed = cmd.push_press | on_reg;
        wr_item.stamp   = now_reg;
    end

    // The read port follows the head pointer, pre-advanced on a pop; a push into an empty queue reads its slot.
    logic [QW-1:0] raddr;
    always_comb begin
        raddr = rd_ptr_reg;
        if (cmd.pop) begin
            raddr = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    thkr_ram #(.WIDTH(HW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .we        (cmd.push),
        .waddr     (wr_ptr_reg),
        .wdata     (wr_item),
        .raddr     ((cmd.push && count_reg == '0) ? wr_ptr_reg : raddr),
        .rdata_reg (head_bits)
    );
    assign head = held_t'(head_bits);

    always_comb begin
        to_eff = timeout_reg;
        if (pend_valid_reg && bind_reg[pend_reg][15:0] != 16'd0) begin
            to_eff = bind_reg[pend_reg][15:0];
        end
        elapsed = now_reg - head.stamp;
    end

    always_comb begin
        sts.is_tick      = kind_reg;
        sts.pass_through = !avalid_reg || inj_reg;
        sts.is_enable    = on_reg && code_reg == enable_reg;
        sts.is_disable   = on_reg && code_reg == disable_reg;
        sts.mode_off     = mode_reg == MODE_OFF;
        sts.mode_nd      = mode_reg == MODE_NO_DELAY;
        sts.on           = on_reg;
        sts.off          = off_reg;
        sts.empty        = count_reg == '0;
        sts.full         = count_reg >= CW'(QUEUE_DEPTH);
        sts.one_left     = count_reg == CW'(1);
        sts.head_match   = head.addr == addr_reg;
        sts.timed_out    = elapsed > to_eff;
        sts.bind_found   = bind_hit;
        sts.tap_ok       = pend_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= s_kind;
            addr_reg   <= s_key_addr;
            avalid_reg <= s_addr_valid;
            code_reg   <= s_key_code;
            on_reg     <= s_toggled_on;
            off_reg    <= s_toggled_off;
            inj_reg    <= s_injected;
            now_reg    <= s_now_ms;
        end
        if (cmd.load_out) begin
            m_last <= cmd.out_last;
            unique case (cmd.out_src)
                SRC_INPUT: begin
                    m_out_addr    <= addr_reg;
                    m_out_code    <= code_reg;
                    m_out_pressed <= on_reg | cmd.push_press;
                end
                SRC_HEAD: begin
                    m_out_addr    <= head.addr;
                    m_out_code    <= head.code;
                    m_out_pressed <= head.pressed;
                end
                SRC_TAP: begin
                    m_out_addr    <= head.addr;
                    m_out_code    <= bind_reg[pend_reg][31:16];
                    m_out_pressed <= head.pressed;
                end
                SRC_COURTESY: begin
                    m_out_addr    <= head.addr;
                    m_out_code    <= head.code;
                    m_out_pressed <= 1'b0;
                end
                default: begin
                    m_out_addr    <= addr_reg;
                    m_out_code    <= code_reg;
                    m_out_pressed <= on_reg;
                end
            endcase
        end
        if (!aresetn) begin
            timeout_reg    <= RESET_TIMEOUT;
            mode_reg       <= RESET_MODE;
            enable_reg     <= '0;
            disable_reg    <= '0;
            for (int i = 0; i < MAP_ENTRIES; i++) bind_reg[i] <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b1;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_DEFAULT_TIMEOUT: timeout_reg <= cfg_data[15:0];
                    REG_INITIAL_MODE:    mode_reg    <= cfg_data[1:0];
                    REG_ENABLE_CODE:     enable_reg  <= cfg_data[15:0];
                    REG_DISABLE_CODE:    disable_reg <= cfg_data[15:0];
                    default: begin
                        for (int i = 0; i < MAP_ENTRIES; i++) begin
                            if (cfg_index == REG_BINDING_BASE + 3'(i)) begin
                                bind_reg[i] <= cfg_data;
                            end
                        end
                    end
                endcase
            end
            if (cmd.set_mode_on) mode_reg <= MODE_ON;
            else if (cmd.set_mode_off) mode_reg <= MODE_OFF;
            if (cmd.set_binding) begin
                pend_reg       <= bind_hit ? bind_idx : rd_next;
                pend_valid_reg <= 1'b1;
            end
            if (cmd.push) begin
                wr_ptr_reg <= (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (cmd.pop) rd_ptr_reg <= raddr;
            if (cmd.push && !cmd.pop)      count_reg <= count_reg + 1'b1;
            else if (cmd.pop && !cmd.push) count_reg <= count_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

@@ sv/thkr_ctrl.sv @@
`default_nettype none
module thkr_ctrl
    import thkr_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire       m_ready,
    input  thkr_sts_t sts,
    output thkr_cmd_t cmd
);
    // WAIT states let the queue's registered read port settle after a
    // pop before the head is used again.
    typedef enum logic [3:0] {
        ST_IDLE, ST_SETTLE, ST_DECIDE, ST_TAP, ST_TAP_WAIT, ST_FLUSH,
        ST_FLUSH_WAIT, ST_TAIL, ST_OUT
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic   m_valid_next;
    logic   flush_tick_reg, flush_tick_next;
    logic   courtesy_reg, courtesy_next;
    logic   tail_silent;

    assign s_ready = state_reg == ST_IDLE;

    // The tail step emits nothing when a bound press is only queued.
    assign tail_silent = sts.on && sts.bind_found && !sts.mode_nd;

    always_comb begin
        cmd             = '0;
        cmd.out_src     = SRC_INPUT;
        state_next      = state_reg;
        ret_next        = ret_reg;
        m_valid_next    = m_valid;
        flush_tick_next = flush_tick_reg;
        courtesy_next   = courtesy_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SETTLE;
                end
            end
            ST_SETTLE: state_next = ST_DECIDE;
            ST_DECIDE: begin
                flush_tick_next = 1'b0;
                courtesy_next   = 1'b0;
                if (sts.is_tick) begin
                    if (!sts.empty && sts.timed_out) begin
                        flush_tick_next = 1'b1;
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (sts.pass_through) begin
                    cmd.load_out = 1'b1; cmd.out_last = 1'b1;
                    m_valid_next = 1'b1; ret_next = ST_IDLE; state_next = ST_OUT;
                end else if (sts.is_enable) begin
                    cmd.set_mode_on = 1'b1; state_next = ST_IDLE;
                end else if (sts.is_disable) begin
                    cmd.set_mode_off = 1'b1; state_next = ST_IDLE;
                end else if (sts.mode_off) begin
                    cmd.load_out = 1'b1; cmd.out_last = 1'b1;
                    m_valid_next = 1'b1; ret_next = ST_IDLE; state_next = ST_OUT;
                end else if (!sts.empty && sts.off && sts.head_match) begin
                    state_next = ST_TAP;
                end else if (!sts.empty && sts.off && !sts.full) begin
                    cmd.push = 1'b1; state_next = ST_IDLE;
                end else if (!sts.empty) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAP: begin
                cmd.load_out = 1'b1;
                m_valid_next = 1'b1;
                if (sts.mode_nd && sts.tap_ok && !courtesy_reg) begin
                    cmd.out_src   = SRC_COURTESY;
                    courtesy_next = 1'b1;
                    ret_next      = ST_TAP;
                end else begin
                    cmd.out_src  = sts.tap_ok ? SRC_TAP : SRC_HEAD;
                    cmd.pop      = 1'b1;
                    cmd.out_last = sts.one_left && tail_silent;
                    ret_next     = ST_TAP_WAIT;
                end
                state_next = ST_OUT;
            end
            ST_TAP_WAIT: state_next = sts.empty ? ST_TAIL : ST_FLUSH;
            ST_FLUSH: begin
                cmd.load_out = 1'b1; cmd.out_src = SRC_HEAD; cmd.pop = 1'b1;
                cmd.out_last = sts.one_left && (flush_tick_reg || tail_silent);
                m_valid_next = 1'b1; ret_next = ST_FLUSH_WAIT; state_next = ST_OUT;
            end
            ST_FLUSH_WAIT: begin
                if (!sts.empty)         state_next = ST_FLUSH;
                else if (flush_tick_reg) state_next = ST_IDLE;
                else                     state_next = ST_TAIL;
            end
            ST_TAIL: begin
                // After any flush: a press may bind, else pass the event on.
                if (sts.on) cmd.set_binding = 1'b1;
                if (sts.on && sts.bind_found) begin
                    cmd.push = 1'b1; cmd.push_press = 1'b1;
                    if (sts.mode_nd) begin
                        cmd.load_out = 1'b1; cmd.out_last = 1'b1;
                        m_valid_next = 1'b1; ret_next = ST_IDLE; state_next = ST_OUT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.load_out = 1'b1; cmd.out_last = 1'b1;
                    m_valid_next = 1'b1; ret_next = ST_IDLE; state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ret_reg;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            m_valid        <= 1'b0;
            flush_tick_reg <= 1'b0;
            courtesy_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            m_valid        <= m_valid_next;
            flush_tick_reg <= flush_tick_next;
            courtesy_reg   <= courtesy_next;
        end
    end
endmodule
`default_nettype wire

@@ sv/tap_hold_key_resolver_top.sv @@
// Channel  | Handshake              | Payload
// s_       | s_valid / s_ready      | kind, key_addr, addr_valid, key_code, toggles,
//          |                        | injected, now_ms
// m_       | m_valid / m_ready      | out_addr, out_code, out_pressed, last
// cfg_     | cfg_valid / cfg_ready  | cfg_index (3 bits), cfg_data (49 bits)
//
// One item is handled at a time: a capture, a settle and a decision step.
// Each result waits in the output state until it is taken; a flushed or tapped
// entry next passes a wait state, and a courtesy release returns to the tap step.
// Reset is synchronous and active low; the queue needs no clearing pass.
// A stall on the result side holds the controller in its output state.
`default_nettype none
module tap_hold_key_resolver_top
    import thkr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [48:0] cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_kind,
    input  wire  [7:0]  s_key_addr,
    input  wire         s_addr_valid,
    input  wire  [15:0] s_key_code,
    input  wire         s_toggled_on,
    input  wire         s_toggled_off,
    input  wire         s_injected,
    input  wire  [15:0] s_now_ms,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_out_addr,
    output logic [15:0] m_out_code,
    output logic        m_out_pressed,
    output logic        m_last
);
    thkr_cmd_t cmd;
    thkr_sts_t sts;

    // Configuration is taken at any time; the user must write only while idle, unenforced.
    assign cfg_ready = 1'b1;

    thkr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    thkr_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAP_ENTRIES(MAP_ENTRIES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_kind(s_kind), .s_key_addr(s_key_addr), .s_addr_valid(s_addr_valid),
        .s_key_code(s_key_code), .s_toggled_on(s_toggled_on),
        .s_toggled_off(s_toggled_off), .s_injected(s_injected), .s_now_ms(s_now_ms),
        .cmd(cmd), .sts(sts), .m_out_addr(m_out_addr), .m_out_code(m_out_code),
        .m_out_pressed(m_out_pressed), .m_last(m_last)
    );
endmodule
`default_nettype wire

@@ sv/thkr_checker.sv @@
`default_nettype none
module thkr_checker (
    input wire aclk,
    input wire aresetn,
    input wire s_valid,
    input wire s_ready,
    input wire m_valid,
    input wire m_ready,
    input wire m_last
);
    // The input side is closed while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready)
        else $error("input accepted while a result is pending");
    // Results stay until the transfer completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");
    // After a final result the block returns to accepting items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |-> ##[1:3] s_ready)
        else $error("block not ready after final result");
    // No result appears straight after an input transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result too early");
endmodule

bind tap_hold_key_resolver_top thkr_checker u_thkr_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_last(m_last)
);
`default_nettype wire
